/* rtl/core/crpc_pkg.sv */
// Shared types, constants and the CRC-15 byte update for the cell readback checker.
// No dependencies; imported by crpc_frame_step and cell_readback_pec_checker_core.
package crpc_pkg;

  localparam int STACK_CHIPS_DEFAULT = 16;
  localparam logic [14:0] PEC_SEED = 15'd16;
  localparam logic [14:0] PEC_POLY = 15'h4599;
  localparam logic [2:0] POS_PEC_HIGH = 3'd6;
  localparam logic [2:0] POS_PEC_LOW = 3'd7;
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [2:0] pos;
    logic [14:0] crc;
    logic [7:0] held;
  } crpc_state_t;

  typedef struct packed {
    logic has_result;
    logic kind;
    logic [3:0] chip;
    logic [3:0] cell_number;
    logic [15:0] cell_code;
    logic pec_mismatch;
  } crpc_result_t;

  function automatic logic [14:0] crc15_byte(logic [14:0] rem, logic [7:0] din);
    logic [14:0] r;
    logic fb;
    r = rem;
    for (int b = 7; b >= 0; b--) begin
      fb = din[b] ^ r[14];
      r = {r[13:0], 1'b0};
      if (fb) begin
        r = r ^ PEC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/crpc_frame_step.sv */
// Combinational frame step: advances the frame state by one in-range word, forms any result.
// Depends on crpc_pkg for the state and result types and the CRC-15 byte update.
module crpc_frame_step import crpc_pkg::*; #(
  parameter int STACK_CHIPS = STACK_CHIPS_DEFAULT
) (
  input  crpc_state_t  state,
  input  logic [7:0]   rx_byte,
  input  logic [1:0]   group,
  input  logic [3:0]   chip,
  output crpc_state_t  state_next,
  output crpc_result_t result
);

  logic [15:0] received;
  logic [15:0] computed;
  logic [3:0] cell_number;

  assign received = {state.held, rx_byte};
  assign computed = {state.crc, 1'b0};
  assign cell_number = 4'({2'b00, group} * 4'd3) + {2'b00, state.pos[2:1]};

  always_comb begin
    state_next = state;
    result = '0;
    if ({1'b0, chip} < 5'(STACK_CHIPS)) begin
      if (state.pos < POS_PEC_HIGH) begin
        state_next.crc = crc15_byte(state.crc, rx_byte);
        state_next.pos = state.pos + 3'd1;
        if (!state.pos[0]) begin
          state_next.held = rx_byte;
        end else begin
          result.has_result = 1'b1;
          result.kind = KIND_CELL;
          result.chip = chip;
          result.cell_number = cell_number;
          result.cell_code = {rx_byte, state.held};
        end
      end else if (state.pos == POS_PEC_HIGH) begin
        state_next.held = rx_byte;
        state_next.pos = POS_PEC_LOW;
      end else begin
        state_next.pos = 3'd0;
        state_next.crc = PEC_SEED;
        state_next.held = 8'd0;
        result.has_result = 1'b1;
        result.kind = KIND_FRAME;
        result.chip = chip;
        result.pec_mismatch = (received != computed);
      end
    end
  end

endmodule

/* rtl/core/cell_readback_pec_checker_core.sv */
// Cell readback checker: an input register, one frame step, and an output register.
// A result is registered in the output register when the frame step fires, which a stalled output can hold off.
// Throughput is one word per cycle while the output does not stall; the CRC-15 byte update is combinational.
// Synchronous reset clears both registers' valid flags and returns the frame state to byte 0,
// with the CRC at its seed; depends on crpc_pkg and crpc_frame_step.
module cell_readback_pec_checker_core import crpc_pkg::*; #(
  parameter int STACK_CHIPS = STACK_CHIPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  group,
  input  logic [3:0]  chip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [3:0]  chip_out,
  output logic [3:0]  cell_number,
  output logic [15:0] cell_code,
  output logic        pec_mismatch
);

  logic s1_valid;
  logic [7:0] s1_byte;
  logic [1:0] s1_group;
  logic [3:0] s1_chip;
  crpc_state_t state;
  crpc_state_t state_next;
  crpc_result_t result;
  logic fire;
  logic in_accept;

  crpc_frame_step #(.STACK_CHIPS(STACK_CHIPS)) u_step (
    .state      (state),
    .rx_byte    (s1_byte),
    .group      (s1_group),
    .chip       (s1_chip),
    .state_next (state_next),
    .result     (result)
  );

  assign fire = s1_valid && (!result.has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_byte <= rx_byte;
      s1_group <= group;
      s1_chip <= chip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.pos <= 3'd0;
      state.crc <= PEC_SEED;
      state.held <= 8'd0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && result.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire && result.has_result) begin
      kind <= result.kind;
      chip_out <= result.chip;
      cell_number <= result.cell_number;
      cell_code <= result.cell_code;
      pec_mismatch <= result.pec_mismatch;
    end
  end

  a_frame_end_resets: assert property (@(posedge clk) disable iff (rst)
    (fire && result.has_result && result.kind == KIND_FRAME) |=>
    (state.pos == 3'd0 && state.crc == PEC_SEED))
    else $error("frame state not restored after frame check");

  a_stall_needs_work: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_frame_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FRAME) |-> (cell_code == 16'd0 && cell_number == 4'd0))
    else $error("frame check word carries cell fields");

  a_cell_no_mismatch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_CELL) |-> !pec_mismatch)
    else $error("cell code word carries a mismatch flag");

endmodule

/* tb/tb_cell_readback_pec_checker_core.sv */
// Testbench for cell_readback_pec_checker_core: byte frames go in, and a predictor checks each
// cell code word and frame PEC verdict that comes out, under input gaps and output stalls.
// Depends on crpc_pkg and the RTL of cell_readback_pec_checker_core only.
`timescale 1ns / 1ps

module tb_cell_readback_pec_checker_core;
  import crpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic kind;
    logic [3:0] chip;
    logic [3:0] cell_number;
    logic [15:0] cell_code;
    logic pec_mismatch;
  } readback_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic [1:0] group = 2'd0;
  logic [3:0] chip = 4'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [3:0] chip_out;
  logic [3:0] cell_number;
  logic [15:0] cell_code;
  logic pec_mismatch;

  readback_result_t pending_results[$];
  readback_result_t oldest_result;
  logic [2:0] frame_pos = 3'd0;
  logic [14:0] frame_crc = PEC_SEED;
  logic [7:0] frame_held = 8'h00;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int bad_frames_sent = 0;

  cell_readback_pec_checker_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .group(group),
    .chip(chip),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .chip_out(chip_out),
    .cell_number(cell_number),
    .cell_code(cell_code),
    .pec_mismatch(pec_mismatch)
  );

  always #5 clk = ~clk;

  function automatic logic [14:0] pec_crc_byte(logic [14:0] rem, logic [7:0] data);
    logic [14:0] r;
    logic fb;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      fb = data[7 - i] ^ r[14];
      r = r << 1;
      if (fb) begin
        r = r ^ PEC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void predict_readback(logic [7:0] rx, logic [1:0] grp, logic [3:0] chp);
    readback_result_t res;
    res = '0;
    if (int'(chp) >= STACK_CHIPS_DEFAULT) begin
      return;
    end
    if (frame_pos < POS_PEC_HIGH) begin
      frame_crc = pec_crc_byte(frame_crc, rx);
      if (!frame_pos[0]) begin
        frame_held = rx;
      end else begin
        res.kind = KIND_CELL;
        res.chip = chp;
        res.cell_number = {2'b00, grp} * 4'd3 + {2'b00, frame_pos[2:1]};
        res.cell_code = {rx, frame_held};
        pending_results.push_back(res);
      end
      frame_pos = frame_pos + 3'd1;
    end else if (frame_pos == POS_PEC_HIGH) begin
      frame_held = rx;
      frame_pos = POS_PEC_LOW;
    end else begin
      res.kind = KIND_FRAME;
      res.chip = chp;
      res.pec_mismatch = ({frame_held, rx} != {frame_crc, 1'b0});
      pending_results.push_back(res);
      frame_pos = 3'd0;
      frame_crc = PEC_SEED;
      frame_held = 8'h00;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served <= holds_requested;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, kind", int'(kind), 0);
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (kind !== oldest_result.kind)
          report_mismatch("kind", int'(kind), int'(oldest_result.kind));
        if (chip_out !== oldest_result.chip)
          report_mismatch("chip_out", int'(chip_out), int'(oldest_result.chip));
        if (cell_number !== oldest_result.cell_number)
          report_mismatch("cell_number", int'(cell_number), int'(oldest_result.cell_number));
        if (cell_code !== oldest_result.cell_code)
          report_mismatch("cell_code", int'(cell_code), int'(oldest_result.cell_code));
        if (pec_mismatch !== oldest_result.pec_mismatch)
          report_mismatch("pec_mismatch", int'(pec_mismatch),
                          int'(oldest_result.pec_mismatch));
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic [1:0] g, input logic [3:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    group <= g;
    chip <= c;
    do @(posedge clk); while (in_stall);
    predict_readback(b, g, c);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] data [6], input logic [1:0] g,
                            input logic [3:0] c, input bit bad_pec, input bit mixed_tags);
    logic [14:0] crc;
    logic [15:0] pec;
    crc = PEC_SEED;
    for (int i = 0; i < 6; i++) begin
      crc = pec_crc_byte(crc, data[i]);
    end
    pec = {crc, 1'b0};
    if (bad_pec) begin
      pec = pec ^ (16'd1 << $urandom_range(15));
      bad_frames_sent++;
    end
    for (int i = 0; i < 8; i++) begin
      if (mixed_tags) begin
        g = 2'($urandom_range(3));
        c = 4'($urandom_range(15));
      end
      if (i < 6) send_word(data[i], g, c);
      else if (i == 6) send_word(pec[15:8], g, c);
      else send_word(pec[7:0], g, c);
    end
  endtask

  task automatic send_random_frame(input bit bad_pec, input bit mixed_tags);
    logic [7:0] data [6];
    for (int i = 0; i < 6; i++) begin
      data[i] = 8'($urandom_range(255));
    end
    send_frame(data, 2'($urandom_range(3)), 4'($urandom_range(15)), bad_pec, mixed_tags);
  endtask

  task automatic test_directed_frames();
    logic [7:0] zeros [6];
    logic [7:0] ones [6];
    for (int i = 0; i < 6; i++) begin
      zeros[i] = 8'h00;
      ones[i] = 8'hff;
    end
    send_frame(zeros, 2'd0, 4'd0, 1'b0, 1'b0);
    send_frame(ones, 2'd3, 4'd15, 1'b1, 1'b0);
    send_random_frame(1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_frames(input int n_frames);
    int n_noise;
    for (int f = 0; f < n_frames; f++) begin
      if ($urandom_range(99) < 8) begin
        n_noise = $urandom_range(3, 1);
        repeat (n_noise) begin
          send_word(8'($urandom_range(255)), 2'($urandom_range(3)), 4'($urandom_range(15)));
        end
      end
      while (frame_pos != 3'd0) begin
        send_word(8'($urandom_range(255)), 2'($urandom_range(3)), 4'($urandom_range(15)));
      end
      send_random_frame($urandom_range(4) == 0, $urandom_range(9) == 0);
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holds_requested++;
    repeat (3) send_random_frame(1'($urandom_range(1)), 1'b0);
    wait_drained();
  endtask

  task automatic test_drain_pauses();
    logic [7:0] data [6];
    logic [1:0] g;
    logic [3:0] c;
    send_idle_pct = 30;
    recv_stall_pct = 30;
    send_random_frame(1'b0, 1'b0);
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      data[i] = 8'($urandom_range(255));
    end
    g = 2'($urandom_range(3));
    c = 4'($urandom_range(15));
    send_word(data[0], g, c);
    wait_drained();
    repeat (4) @(posedge clk);
    for (int i = 1; i < 6; i++) begin
      send_word(data[i], g, c);
    end
    wait_drained();
    repeat (4) @(posedge clk);
    send_word(8'($urandom_range(255)), g, c);
    send_word(8'($urandom_range(255)), g, c);
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    send_idle_pct = 16;
    recv_stall_pct = 56;
    test_random_frames(45);
    send_idle_pct = 56;
    recv_stall_pct = 16;
    test_random_frames(45);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_frames(45);
    test_output_hold();
    test_drain_pauses();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d words and checked %0d results, %0d frames carried a corrupted PEC.",
             words_sent, results_checked, bad_frames_sent);
    $display("Covered directed extremes, three idle mixes, a long output hold and drains.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
